FILE: rtl/lead_lag_filter_step_assert.svh
// Assertion macros shared by the lead-lag filter RTL.
`ifndef LEAD_LAG_FILTER_STEP_ASSERT_SVH
`define LEAD_LAG_FILTER_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LLFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LLFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/llfs_pkg.sv
// Shared types, constants and helpers of the lead-lag filter.
package llfs_pkg;

  localparam int unsigned LLFS_FRAC_BITS = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned DIV_STEPS      = 32;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned NUM_LANES      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_GAIN    = 3'd0,
    CFG_LEAD_CONST   = 3'd1,
    CFG_LAG_GAIN     = 3'd2,
    CFG_LAG_CONST    = 3'd3,
    CFG_START_OUTPUT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_DEN,
    S_PREP,
    S_DIV,
    S_COEF,
    S_MULA,
    S_MULB,
    S_MULC,
    S_SUM,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_DT_C2,
    MUL_DT_C4,
    MUL_U_CA,
    MUL_UP_CB,
    MUL_YP_CC
  } mul_sel_e;

  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     dc2_load;
    logic     den_load;
    logic     div_init;
    logic     div_step;
    logic     coef_load;
    logic     acc_init;
    logic     acc_add;
    logic     state_update;
    logic     out_load;
    logic     out_flag;
  } cmd_t;

  typedef struct packed {
    logic dt_pos;
    logic den_zero;
  } status_t;

  // Clamps a wide signed value into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/llfs_ctrl.sv
// Sequencer of the lead-lag filter: state machine, divide counter, output valid.
`include "lead_lag_filter_step_assert.svh"

module llfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  llfs_pkg::status_t sts_i,
  output llfs_pkg::cmd_t    cmd_o
);
  import llfs_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 flag_q, flag_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_accept;
  logic                 slot_free;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    flag_d    = flag_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL0;
      S_MUL0: begin
        flag_d  = 1'b0;
        state_d = sts_i.dt_pos ? S_MUL1 : S_DONE;
      end
      S_MUL1: state_d = S_DEN;
      S_DEN:  state_d = S_PREP;
      S_PREP: begin
        flag_d    = sts_i.den_zero;
        div_cnt_d = '0;
        state_d   = sts_i.den_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_COEF;
      end
      S_COEF: state_d = S_MULA;
      S_MULA: state_d = S_MULB;
      S_MULB: state_d = S_MULC;
      S_MULC: state_d = S_SUM;
      S_SUM:  state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_DT_C2;
    cmd_o.out_flag = flag_q;
    unique case (state_q)
      S_IDLE: cmd_o.in_load = in_valid_i;
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DT_C2;
      end
      S_MUL1: begin
        cmd_o.dc2_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_DT_C4;
      end
      S_DEN:  cmd_o.den_load  = 1'b1;
      S_PREP: cmd_o.div_init  = 1'b1;
      S_DIV:  cmd_o.div_step  = 1'b1;
      S_COEF: cmd_o.coef_load = 1'b1;
      S_MULA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_U_CA;
      end
      S_MULB: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_UP_CB;
      end
      S_MULC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_YP_CC;
      end
      S_SUM:  cmd_o.state_update = 1'b1;
      S_DONE: cmd_o.out_load     = slot_free;
      default: cmd_o.in_load     = 1'b0;
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `LLFS_ASSERT_NEXT(a_accept_starts, in_accept, state_q == S_MUL0, "accept did not start work")
  `LLFS_ASSERT_NOW(a_load_slot_free, cmd_o.out_load, !out_valid_q || !out_stall_i, "result overrun")
  `LLFS_ASSERT_NEXT(a_div_entry, (state_q == S_PREP) && !sts_i.den_zero, (state_q == S_DIV) && (div_cnt_q == '0), "divide entry broken")
  `LLFS_ASSERT_NEXT(a_update_done, cmd_o.state_update, (state_q == S_DONE) && !flag_q, "update not followed by clean result")

endmodule

FILE: rtl/llfs_datapath.sv
// Datapath of the lead-lag filter: registers, shared multiplier, three-lane divider.
module llfs_datapath #(
  parameter int unsigned FRAC_BITS = llfs_pkg::LLFS_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [llfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [llfs_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  logic signed [llfs_pkg::DATA_W-1:0]  step_time_i,
  input  logic signed [llfs_pkg::DATA_W-1:0]  sample_in_i,
  input  llfs_pkg::cmd_t                      cmd_i,
  output llfs_pkg::status_t                   sts_o,
  output logic signed [llfs_pkg::DATA_W-1:0]  filtered_out_o,
  output logic                                den_zero_o
);
  import llfs_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

  // Configuration and filter state.
  logic signed [DATA_W-1:0] lead_gain_q, lead_const_q, lag_gain_q, lag_const_q;
  logic signed [DATA_W-1:0] start_output_q;
  logic signed [DATA_W-1:0] last_output_q, last_input_q;

  // Working registers for one transaction.
  logic signed [DATA_W-1:0] dt_q, u_q;
  logic signed [63:0]       prod_q, dc2_q, acc_q;
  logic signed [DATA_W-1:0] den_q;
  logic signed [DATA_W-1:0] num_q  [NUM_LANES];
  logic        [DATA_W-1:0] dmag_q;
  logic        [DATA_W-1:0] rem_q  [NUM_LANES];
  logic        [DATA_W-1:0] lo_q   [NUM_LANES];
  logic        [DATA_W-1:0] quo_q  [NUM_LANES];
  logic                     sat_q  [NUM_LANES];
  logic                     sgn_q  [NUM_LANES];
  logic signed [DATA_W-1:0] coef_q [NUM_LANES];

  logic signed [DATA_W-1:0] out_q;
  logic                     flag_q;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       prod_shift;
  logic signed [63:0]       two_c1, two_c3;
  logic        [DATA_W-1:0] dmag;
  logic        [DATA_W-1:0] nmag   [NUM_LANES];
  logic        [63:0]       nfull  [NUM_LANES];
  logic        [DATA_W:0]   trial  [NUM_LANES];
  logic                     ge     [NUM_LANES];
  logic        [DATA_W:0]   diff   [NUM_LANES];
  logic signed [DATA_W-1:0] coef_d [NUM_LANES];

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_DT_C2: begin mul_a = dt_q;          mul_b = lead_const_q; end
      MUL_DT_C4: begin mul_a = dt_q;          mul_b = lag_const_q;  end
      MUL_U_CA:  begin mul_a = u_q;           mul_b = coef_q[0];    end
      MUL_UP_CB: begin mul_a = last_input_q;  mul_b = coef_q[1];    end
      MUL_YP_CC: begin mul_a = last_output_q; mul_b = coef_q[2];    end
      default:   begin mul_a = dt_q;          mul_b = lead_const_q; end
    endcase
  end

  // Arithmetic shift of the exact product floors toward minus infinity.
  assign prod_shift = prod_q >>> FRAC_BITS;
  assign two_c1     = {{(63 - DATA_W){lead_gain_q[DATA_W-1]}}, lead_gain_q, 1'b0};
  assign two_c3     = {{(63 - DATA_W){lag_gain_q[DATA_W-1]}}, lag_gain_q, 1'b0};
  assign dmag       = den_q[DATA_W-1] ? DATA_W'(-den_q) : DATA_W'(den_q);

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      nmag[i]  = num_q[i][DATA_W-1] ? DATA_W'(-num_q[i]) : DATA_W'(num_q[i]);
      nfull[i] = {32'd0, nmag[i]} << FRAC_BITS;
      trial[i] = {rem_q[i], lo_q[i][DATA_W-1]};
      ge[i]    = (trial[i] >= {1'b0, dmag_q});
      diff[i]  = trial[i] - {1'b0, dmag_q};
      if (sgn_q[i]) begin
        if (sat_q[i] || (quo_q[i][DATA_W-1] && (|quo_q[i][DATA_W-2:0]))) begin
          coef_d[i] = 32'sh8000_0000;
        end else begin
          coef_d[i] = -$signed(quo_q[i]);
        end
      end else begin
        if (sat_q[i] || quo_q[i][DATA_W-1]) begin
          coef_d[i] = 32'sh7FFF_FFFF;
        end else begin
          coef_d[i] = $signed(quo_q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_gain_q    <= '0;
      lead_const_q   <= ONE_Q;
      lag_gain_q     <= '0;
      lag_const_q    <= ONE_Q;
      start_output_q <= '0;
      last_output_q  <= '0;
      last_input_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEAD_GAIN:  lead_gain_q  <= cfg_wdata_i;
          CFG_LEAD_CONST: lead_const_q <= cfg_wdata_i;
          CFG_LAG_GAIN:   lag_gain_q   <= cfg_wdata_i;
          CFG_LAG_CONST:  lag_const_q  <= cfg_wdata_i;
          CFG_START_OUTPUT: begin
            start_output_q <= cfg_wdata_i;
            last_output_q  <= cfg_wdata_i;
          end
          default: start_output_q <= start_output_q;
        endcase
      end
      if (cmd_i.state_update) begin
        last_output_q <= sat32(acc_q + prod_shift);
        last_input_q  <= u_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      dt_q <= step_time_i;
      u_q  <= sample_in_i;
    end
    if (cmd_i.mul_en)   prod_q <= mul_a * mul_b;
    if (cmd_i.dc2_load) dc2_q  <= prod_shift;
    if (cmd_i.den_load) begin
      den_q    <= sat32(two_c3 + prod_shift);
      num_q[0] <= sat32(two_c1 + dc2_q);
      num_q[1] <= sat32(dc2_q - two_c1);
      num_q[2] <= sat32(two_c3 - prod_shift);
    end
    if (cmd_i.div_init) begin
      dmag_q <= dmag;
      for (int i = 0; i < NUM_LANES; i++) begin
        rem_q[i] <= nfull[i][63:32];
        lo_q[i]  <= nfull[i][31:0];
        quo_q[i] <= '0;
        sat_q[i] <= (nfull[i][63:32] >= dmag);
        sgn_q[i] <= num_q[i][DATA_W-1] ^ den_q[DATA_W-1];
      end
    end
    if (cmd_i.div_step) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        rem_q[i] <= ge[i] ? diff[i][DATA_W-1:0] : trial[i][DATA_W-1:0];
        lo_q[i]  <= {lo_q[i][DATA_W-2:0], 1'b0};
        quo_q[i] <= {quo_q[i][DATA_W-2:0], ge[i]};
      end
    end
    if (cmd_i.coef_load) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        coef_q[i] <= coef_d[i];
      end
    end
    if (cmd_i.acc_init) acc_q <= prod_shift;
    if (cmd_i.acc_add)  acc_q <= acc_q + prod_shift;
    if (cmd_i.out_load) begin
      out_q  <= last_output_q;
      flag_q <= cmd_i.out_flag;
    end
  end

  assign sts_o.dt_pos   = !dt_q[DATA_W-1] && (|dt_q);
  assign sts_o.den_zero = (den_q == '0);
  assign filtered_out_o = out_q;
  assign den_zero_o     = flag_q;

endmodule

FILE: rtl/lead_lag_filter_step.sv
// Top level of the lead-lag filter: sequencer and datapath wired together.
// A full update runs both step multiplies, the denominator, the divide, the three
// multiply-accumulates and the state update; a nonpositive step or a zero denominator skips to the result.
// One transaction at a time: a full update is paced by the 32-step divider and the shared
// 32x32 multiplier, and input waits until the result is stored.
// Reset (rst_ni low, asynchronous): configuration registers take defaults, stored state zero, no result.
module lead_lag_filter_step #(
  parameter int unsigned FRAC_BITS = llfs_pkg::LLFS_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [llfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [llfs_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [llfs_pkg::DATA_W-1:0]  step_time_i,
  input  logic signed [llfs_pkg::DATA_W-1:0]  sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [llfs_pkg::DATA_W-1:0]  filtered_out_o,
  output logic                                den_zero_o
);
  import llfs_pkg::*;

  // The sequencer drives commands and reads a small status word back; that is the
  // only connection between the two halves.
  cmd_t    cmd;
  status_t sts;

  // The sequencer walks each transaction through: two multiplies for the step
  // products, the denominator and numerators, a divide that runs all three
  // coefficients side by side, three multiply-accumulates, and the state
  // update. The result sits in an output register so the next input can be taken
  // while it waits downstream.
  llfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath also holds the configuration registers. Writes to the starting
  // output register reload the stored output immediately; unknown indexes are ignored.
  llfs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .step_time_i    (step_time_i),
    .sample_in_i    (sample_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .filtered_out_o (filtered_out_o),
    .den_zero_o     (den_zero_o)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the lead-lag filter step block, with a built-in predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llfs_pkg::*;

  // The run is ended by force after this long. A correct run needs well under a fifth of it.
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

  // Q16.16 values that the stimulus uses again and again.
  localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

  // The highest register index that the port can carry. Indexes past the start
  // output register select nothing, and a write to one of them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  // Clock cycles that a long receiver hold lasts.
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [DATA_W-1:0] step_time;
    logic signed [DATA_W-1:0] sample;
  } step_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_out;
    logic                     den_zero;
  } filter_result_t;

  // Every input of the block starts at a known value.
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [DATA_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic signed [DATA_W-1:0] step_time_i = '0;
  logic signed [DATA_W-1:0] sample_in_i = '0;
  logic                     out_stall_i = 1'b0;

  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] filtered_out_o;
  logic                     den_zero_o;

  // Items waiting to be sent, and the results that the accepted ones must produce.
  step_item_t     pending_steps[$];
  filter_result_t expected_outputs[$];

  int unsigned fail_count = 0;

  // Idle switches that the stimulus sets per phase, so that some stretches run at full speed.
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;

  // Predictor copy of the coefficient registers and the filter state, at reset values.
  longint lead_c1   = 0;
  longint lead_c2   = 64'sd65536;
  longint lag_c3    = 0;
  longint lag_c4    = 64'sd65536;
  longint y_prev    = 0;
  longint u_prev    = 0;

  lead_lag_filter_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .step_time_i    (step_time_i),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_out_o (filtered_out_o),
    .den_zero_o     (den_zero_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in 64-bit signed integers, which hold every
  // intermediate exactly: products of two Q values stay at or below 2^62 in magnitude.
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Fixed-point product; the arithmetic shift floors toward minus infinity.
  function automatic longint qprod(input longint a, input longint b);
    return (a * b) >>> LLFS_FRAC_BITS;
  endfunction

  // Fixed-point quotient; integer division truncates toward zero, then the value clamps.
  function automatic longint coef_ratio(input longint num, input longint den);
    return clamp32((num <<< LLFS_FRAC_BITS) / den);
  endfunction

  // Works out the result of one transaction and moves the filter state along with it.
  // A nonpositive step leaves everything alone, and so does a zero denominator, which
  // in addition raises the flag.
  function automatic filter_result_t advance_filter(input logic signed [DATA_W-1:0] dt_in,
                                                    input logic signed [DATA_W-1:0] u_in);
    filter_result_t res;
    longint dt, u, dc2, dc4, den, na, nb, nc, ca, cb, cc;
    dt = dt_in;
    u  = u_in;
    res.den_zero = 1'b0;
    if (dt > 0) begin
      dc2 = qprod(dt, lead_c2);
      dc4 = qprod(dt, lag_c4);
      den = clamp32(2 * lag_c3 + dc4);
      if (den == 0) begin
        res.den_zero = 1'b1;
      end else begin
        na = clamp32(2 * lead_c1 + dc2);
        nb = clamp32(dc2 - 2 * lead_c1);
        nc = clamp32(2 * lag_c3 - dc4);
        ca = coef_ratio(na, den);
        cb = coef_ratio(nb, den);
        cc = coef_ratio(nc, den);
        y_prev = clamp32(qprod(u, ca) + qprod(u_prev, cb) + qprod(y_prev, cc));
        u_prev = u;
      end
    end
    res.filtered_out = y_prev[DATA_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. One transaction is offered at a time from the pending queue. After each
  // accepted transaction it draws an idle gap, and now and then it holds back until
  // every outstanding result has come back, so that the block runs completely dry.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : step_driver
    int unsigned send_gap;
    int unsigned sent_count;
    bit          hold_for_drain;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      send_gap       = 0;
      sent_count     = 0;
      hold_for_drain = 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      // Either nothing is on offer or the offered item went through at this edge.
      if (in_valid_i) begin
        expected_outputs.push_back(advance_filter(pending_steps[0].step_time,
                                                  pending_steps[0].sample));
        void'(pending_steps.pop_front());
        sent_count++;
        send_gap = sender_idles ? $urandom_range(0, 14) : 0;
        if (sent_count == 120 || $urandom_range(0, 149) == 0) begin
          hold_for_drain = 1'b1;
        end
      end
      if (hold_for_drain && expected_outputs.size() == 0) begin
        hold_for_drain = 1'b0;
      end
      if (send_gap > 0 || hold_for_drain || pending_steps.size() == 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i  <= 1'b1;
        step_time_i <= pending_steps[0].step_time;
        sample_in_i <= pending_steps[0].sample;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each accepted result is checked against the oldest expectation. The
  // stall count drawn per result only runs down while a result is on offer, so the
  // stalls land on results. Once early on, and at random later, the receiver holds
  // off for a long stretch; the block then fills and must stall its input.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    filter_result_t want;
    int unsigned    stall_left;
    int unsigned    long_hold_left;
    int unsigned    results_seen;
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      stall_left     = 0;
      long_hold_left = 0;
      results_seen   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result: filtered_out %0d, den_zero %0b", filtered_out_o,
                 den_zero_o);
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (filtered_out_o !== want.filtered_out) begin
            $error("filtered_out mismatch: expected %0d, actual %0d", want.filtered_out,
                   filtered_out_o);
            fail_count++;
          end
          if (den_zero_o !== want.den_zero) begin
            $error("den_zero mismatch: expected %0b, actual %0b", want.den_zero, den_zero_o);
            fail_count++;
          end
        end
        results_seen++;
        stall_left = receiver_idles ? $urandom_range(0, 14) : 0;
        if (results_seen == 40 || $urandom_range(0, 199) == 0) begin
          long_hold_left = LONG_HOLD_CYCLES;
        end
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
      end
      out_stall_i <= (long_hold_left > 0) || (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Writes one register at a clock edge and mirrors it in the predictor. Loading the
  // start output also loads the stored output at once; the stored input stays.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LEAD_GAIN:    lead_c1 = $signed(data);
      CFG_LEAD_CONST:   lead_c2 = $signed(data);
      CFG_LAG_GAIN:     lag_c3  = $signed(data);
      CFG_LAG_CONST:    lag_c4  = $signed(data);
      CFG_START_OUTPUT: y_prev  = $signed(data);
      default: ;
    endcase
  endtask

  task automatic load_filter(input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2,
                             input logic [DATA_W-1:0] c3, input logic [DATA_W-1:0] c4);
    write_reg(CFG_LEAD_GAIN, c1);
    write_reg(CFG_LEAD_CONST, c2);
    write_reg(CFG_LAG_GAIN, c3);
    write_reg(CFG_LAG_CONST, c4);
  endtask

  // Waits until every item went in and every result came out, then lets the block
  // settle and returns on a falling edge, away from the driver.
  task automatic settle_block();
    while (pending_steps.size() != 0 || expected_outputs.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Most steps are positive, and short when short_steps is set, to keep a well-tuned
  // filter running; the rest are long steps, zero and negative steps and raw 32-bit noise.
  function automatic step_item_t random_step(input bit short_steps);
    step_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.step_time = short_steps ? $urandom_range(1, 6554) : $urandom_range(1, 1 << 18);
    end else if (pick < 70) begin
      it.step_time = $urandom_range(1, 1 << 22);
    end else if (pick < 78) begin
      it.step_time = '0;
    end else if (pick < 86) begin
      it.step_time = ~32'($urandom_range(0, 1 << 20));
    end else begin
      it.step_time = $urandom();
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.sample = $urandom_range(0, 1 << 21) - (1 << 20);
    end else if (pick < 80) begin
      it.sample = $urandom();
    end else if (pick < 88) begin
      it.sample = Q_MIN;
    end else if (pick < 96) begin
      it.sample = Q_MAX;
    end else begin
      it.sample = '0;
    end
    return it;
  endfunction

  task automatic run_phase(input int unsigned count, input bit short_steps, input bit tx_idle,
                           input bit rx_idle);
    sender_idles   = tx_idle;
    receiver_idles = rx_idle;
    repeat (count) pending_steps.push_back(random_step(short_steps));
    settle_block();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Registers change only between phases, with the block idle.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset coefficients make every coefficient one or minus one. Covers a zero
    // and a negative step, the smallest positive step and the field extremes.
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    pending_steps.push_back(step_item_t'{32'sd0, Q_ONE});
    pending_steps.push_back(step_item_t'{-32'sd1, Q_MAX});
    pending_steps.push_back(step_item_t'{Q_MIN, Q_MIN});
    pending_steps.push_back(step_item_t'{32'sd1, Q_MAX});
    pending_steps.push_back(step_item_t'{Q_ONE, Q_ONE});
    pending_steps.push_back(step_item_t'{Q_MAX, Q_MAX});
    pending_steps.push_back(step_item_t'{Q_MAX, Q_MIN});
    pending_steps.push_back(step_item_t'{Q_ONE, 32'sd0});
    pending_steps.push_back(step_item_t'{Q_ONE, Q_MIN});
    settle_block();

    // A negative lag gain of one half cancels the step term at a step of one, so the
    // denominator goes to zero there. Also loads a start output and writes to an
    // index that selects no register.
    load_filter(Q_ONE, Q_ONE, -Q_HALF, Q_ONE);
    write_reg(CFG_START_OUTPUT, 32'h1234_5678);
    write_reg(CFG_IDX_LAST, 32'hFFFF_FFFF);
    pending_steps.push_back(step_item_t'{Q_ONE, Q_ONE});
    pending_steps.push_back(step_item_t'{32'sh0002_0000, Q_MAX});
    pending_steps.push_back(step_item_t'{Q_MAX, Q_MIN});
    pending_steps.push_back(step_item_t'{Q_ONE, 32'sd0});
    pending_steps.push_back(step_item_t'{Q_MIN, Q_ONE});
    pending_steps.push_back(step_item_t'{32'sd0, 32'sd0});
    pending_steps.push_back(step_item_t'{32'sd1, Q_MAX});
    settle_block();

    // The smallest lag constant floors the step term to zero for any step below one,
    // and a step of one gives a denominator of one LSB, which drives coefficients to
    // saturation.
    load_filter(Q_MAX, Q_MIN, 32'sd0, 32'sd1);
    pending_steps.push_back(step_item_t'{32'sd100, 32'sd5});
    pending_steps.push_back(step_item_t'{Q_MAX, Q_MAX});
    pending_steps.push_back(step_item_t'{Q_ONE, Q_MIN});
    pending_steps.push_back(step_item_t'{32'sd1, -32'sd1});
    settle_block();

    // A well-behaved lead filter with small steps, first with idling on both sides,
    // then at full speed.
    load_filter($urandom_range(0, 1 << 17), Q_ONE, $urandom_range(3277, 65536), Q_ONE);
    write_reg(CFG_START_OUTPUT, $urandom_range(0, 1 << 20));
    run_phase(150, 1'b1, 1'b1, 1'b1);
    run_phase(150, 1'b1, 1'b0, 1'b0);

    // All coefficients at the largest value, then all at the smallest.
    load_filter(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    write_reg(CFG_START_OUTPUT, Q_MAX);
    run_phase(150, 1'b0, 1'b0, 1'b1);
    load_filter(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    write_reg(CFG_START_OUTPUT, Q_MIN);
    run_phase(150, 1'b0, 1'b1, 1'b0);

    // All coefficients zero: every positive step meets a zero denominator.
    load_filter(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    write_reg(CFG_START_OUTPUT, 32'sd0);
    run_phase(150, 1'b0, 1'b1, 1'b1);

    // Raw random registers, including a write to an index past the list.
    load_filter($urandom(), $urandom(), $urandom(), $urandom());
    write_reg(CFG_START_OUTPUT, $urandom());
    write_reg(CFG_IDX_W'($urandom_range(CFG_START_OUTPUT + 1, CFG_IDX_LAST)), $urandom());
    run_phase(150, 1'b0, 1'b1, 1'b1);

    // A tiny lag constant with no lag gain: short steps often floor to a zero
    // denominator, longer ones do not.
    load_filter($urandom_range(0, 1 << 18), $urandom(), 32'sd0, $urandom_range(1, 16));
    run_phase(150, 1'b1, 1'b1, 1'b1);

    // A lag filter with a negative lead gain and a fresh start output.
    load_filter(-$urandom_range(0, 1 << 17), $urandom_range(1 << 15, 1 << 17),
                $urandom_range(6554, 1 << 17), $urandom_range(1 << 15, 1 << 17));
    write_reg(CFG_START_OUTPUT, $urandom_range(0, 1 << 21) - (1 << 20));
    run_phase(150, 1'b1, 1'b1, 1'b1);

    // Let any stray result show up before the verdict.
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
